@@ rtl/core/epoch_us_to_calendar_date_macros.svh @@
// ----------------------------------------------------------------------------
// Epoch to calendar date: assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EPOCH_US_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_US_TO_CALENDAR_DATE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define EUCD_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EUCD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/eucd_pkg.sv @@
// ----------------------------------------------------------------------------
// Epoch to calendar date: package
// Divisors, range limit, month tables and the shared long-division step.
// ----------------------------------------------------------------------------
`default_nettype none

package eucd_pkg;

  localparam logic [63:0] END_US     = 64'd4102444800000000;
  localparam logic [19:0] US_PER_SEC = 20'd1000000;
  // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15, 1460 = 4 * 365
  localparam logic [19:0] DAY_DIV    = 20'd675;
  localparam logic [19:0] HOUR_DIV   = 20'd225;
  localparam logic [19:0] MIN_DIV    = 20'd15;
  localparam logic [19:0] YEAR_DIV   = 20'd365;
  localparam logic [11:0] BASE_YEAR  = 12'd1970;

  typedef logic [8:0] cum_tab_t [13];

  localparam cum_tab_t CUM_COMMON = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
                                      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
  localparam cum_tab_t CUM_LEAP   = '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
                                      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  // Returns {quotient bit, new remainder}. Remainder is always below the divisor.
  function automatic logic [20:0] div_step(input logic [19:0] rem, input logic din,
                                           input logic [19:0] dv);
    logic [20:0] sh;
    logic [20:0] df;
    sh = {rem, din};
    df = sh - {1'b0, dv};
    if (sh >= {1'b0, dv}) begin
      return {1'b1, df[19:0]};
    end else begin
      return {1'b0, sh[19:0]};
    end
  endfunction

  // x mod 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [16:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = {4'd0, x[16:15]} + {3'd0, x[14:12]} + {3'd0, x[11:9]} + {3'd0, x[8:6]}
       + {3'd0, x[5:3]} + {3'd0, x[2:0]};
    s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
    s3 = {2'd0, s2[3]} + s2[2:0];
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/eucd_stream_if.sv @@
// ----------------------------------------------------------------------------
// Epoch to calendar date: stream interfaces
// Valid/ready channels for the timestamp input and the date result.
// ----------------------------------------------------------------------------
`default_nettype none

interface eucd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] timestamp_us;

  modport source (output valid, output timestamp_us, input ready);
  modport sink   (input valid, input timestamp_us, output ready);
endinterface

interface eucd_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] microsecond;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day_of_month;
  logic [3:0]  month;
  logic [11:0] year;
  logic [8:0]  year_day;
  logic [2:0]  week_day;
  logic        out_of_range;

  modport source (output valid, output microsecond, output second, output minute,
                  output hour, output day_of_month, output month, output year,
                  output year_day, output week_day, output out_of_range, input ready);
  modport sink   (input valid, input microsecond, input second, input minute,
                  input hour, input day_of_month, input month, input year,
                  input year_day, input week_day, input out_of_range, output ready);
endinterface

`default_nettype wire

@@ rtl/core/epoch_us_to_calendar_date.sv @@
// Twelve register stages from input beat to result beat.
// One beat per cycle unless the result stalls; the long divisions by 1e6 and 86400
// are spread over eight quotient bits per stage, which sets the stage count.
// A stalled result backs up the pipeline stage by stage; bubbles are filled.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// Epoch to calendar date
// Microsecond epoch count to date and time fields, saturating past 2099.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_us_to_calendar_date (
  input  wire logic      clk,
  input  wire logic      rst_n,
  eucd_in_if.sink        in_ch,
  eucd_out_if.source     out_ch
);

  localparam int unsigned NS = 12;

  typedef struct packed {
    logic        flag;
    logic [19:0] r_us;       // remainder of / 1e6, ends as microsecond
    logic [31:0] secs;       // dividend bits, then seconds since epoch
    logic [9:0]  r_day;      // remainder of (secs >> 7) / 675
    logic [15:0] days;
    logic [6:0]  sec_lo;
    logic [4:0]  hour;
    logic [11:0] hour_secs;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [5:0]  quad;       // (days + 365) / 1460
    logic [7:0]  years;
    logic [2:0]  week_day;
    logic [8:0]  year_day;
    logic [11:0] year;
    logic [3:0]  month;
    logic [8:0]  month_base;
    logic [4:0]  day_of_month;
  } stage_t;

  stage_t            pipe_r [NS];
  stage_t            pipe_nxt [NS];
  logic   [NS-1:0]   v_r;
  logic   [NS-1:0]   ld;

  // per-stage work; k is the stage index, s the previous stage's contents
  function automatic stage_t work(input int unsigned k, input stage_t s);
    stage_t      o;
    logic [20:0] st;
    logic [19:0] r;
    logic [16:0] ds;
    logic [16:0] a;
    logic [15:0] b;
    logic [16:0] yd;
    logic [4:0]  hq;
    logic [5:0]  qq;
    logic [5:0]  mq;
    logic [7:0]  yq;
    logic [10:0] pass;
    logic [3:0]  mi;
    logic        leap;
    logic [8:0]  dom;
    o    = s;
    st   = '0;
    r    = '0;
    ds   = '0;
    a    = '0;
    b    = '0;
    yd   = '0;
    hq   = '0;
    qq   = '0;
    mq   = '0;
    yq   = '0;
    pass = '0;
    mi   = '0;
    leap = 1'b0;
    dom  = '0;
    case (k)
      1, 2, 3, 4: begin
        r = s.r_us;
        for (int j = 0; j < 8; j++) begin
          st     = eucd_pkg::div_step(r, o.secs[31], eucd_pkg::US_PER_SEC);
          r      = st[19:0];
          o.secs = {o.secs[30:0], st[20]};
        end
        o.r_us = r;
      end
      5, 6: begin
        if (k == 5) begin
          // (secs >> 7) / 675: top nine bits are already below the divisor
          r        = {11'd0, s.secs[31:23]};
          o.days   = s.secs[22:7];
          o.sec_lo = s.secs[6:0];
        end else begin
          r = {10'd0, s.r_day};
        end
        for (int j = 0; j < 8; j++) begin
          st     = eucd_pkg::div_step(r, o.days[15], eucd_pkg::DAY_DIV);
          r      = st[19:0];
          o.days = {o.days[14:0], st[20]};
        end
        o.r_day = r[9:0];
      end
      7: begin
        ds = {s.r_day, s.sec_lo};
        r  = {12'd0, ds[16:9]};
        hq = ds[8:4];
        for (int j = 0; j < 5; j++) begin
          st = eucd_pkg::div_step(r, hq[4], eucd_pkg::HOUR_DIV);
          r  = st[19:0];
          hq = {hq[3:0], st[20]};
        end
        o.hour      = hq;
        o.hour_secs = {r[7:0], ds[3:0]};
        a  = {1'b0, s.days} + 17'd365;
        r  = {11'd0, a[16:8]};
        qq = a[7:2];
        for (int j = 0; j < 6; j++) begin
          st = eucd_pkg::div_step(r, qq[5], eucd_pkg::YEAR_DIV);
          r  = st[19:0];
          qq = {qq[4:0], st[20]};
        end
        o.quad     = qq;
        o.week_day = eucd_pkg::mod7({1'b0, s.days} + 17'd4);
      end
      8: begin
        r  = {16'd0, s.hour_secs[11:8]};
        mq = s.hour_secs[7:2];
        for (int j = 0; j < 6; j++) begin
          st = eucd_pkg::div_step(r, mq[5], eucd_pkg::MIN_DIV);
          r  = st[19:0];
          mq = {mq[4:0], st[20]};
        end
        o.minute = mq;
        o.second = {r[3:0], s.hour_secs[1:0]};
        b  = s.days - {10'd0, s.quad};
        r  = {12'd0, b[15:8]};
        yq = b[7:0];
        for (int j = 0; j < 8; j++) begin
          st = eucd_pkg::div_step(r, yq[7], eucd_pkg::YEAR_DIV);
          r  = st[19:0];
          yq = {yq[6:0], st[20]};
        end
        o.years = yq;
      end
      9: begin
        yd = {1'b0, s.days} - ({9'd0, s.years} * 17'd365)
           - (({9'd0, s.years} + 17'd1) >> 2);
        o.year_day = yd[8:0];
        o.year     = eucd_pkg::BASE_YEAR + {4'd0, s.years};
      end
      10: begin
        leap = (s.year[1:0] == 2'b00);
        for (int m = 1; m < 12; m++) begin
          pass[m-1] = leap ? (s.year_day >= eucd_pkg::CUM_LEAP[m])
                           : (s.year_day >= eucd_pkg::CUM_COMMON[m]);
        end
        mi           = 4'($countones(pass));
        o.month      = mi + 4'd1;
        o.month_base = leap ? eucd_pkg::CUM_LEAP[mi] : eucd_pkg::CUM_COMMON[mi];
      end
      11: begin
        dom            = 9'd1 + s.year_day - s.month_base;
        o.day_of_month = dom[4:0];
      end
      default: begin
        o = s;
      end
    endcase
    return o;
  endfunction

  // stage 0: clamp to the last valid instant and load the first divider
  always_comb begin
    pipe_nxt[0] = pipe_r[0];
    if (in_ch.timestamp_us >= eucd_pkg::END_US) begin
      pipe_nxt[0].flag = 1'b1;
      pipe_nxt[0].r_us = 20'((eucd_pkg::END_US - 64'd1) >> 32);
      pipe_nxt[0].secs = 32'(eucd_pkg::END_US - 64'd1);
    end else begin
      pipe_nxt[0].flag = 1'b0;
      // below the limit the top 20 bits are already under 1e6
      pipe_nxt[0].r_us = in_ch.timestamp_us[51:32];
      pipe_nxt[0].secs = in_ch.timestamp_us[31:0];
    end
  end

  for (genvar g = 1; g < NS; g++) begin : g_stage
    assign pipe_nxt[g] = work(g, pipe_r[g-1]);
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ld[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_ch.ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (ld[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  assign out_ch.valid        = v_r[NS-1];
  assign out_ch.microsecond  = pipe_r[NS-1].r_us;
  assign out_ch.second       = pipe_r[NS-1].second;
  assign out_ch.minute       = pipe_r[NS-1].minute;
  assign out_ch.hour         = pipe_r[NS-1].hour;
  assign out_ch.day_of_month = pipe_r[NS-1].day_of_month;
  assign out_ch.month        = pipe_r[NS-1].month;
  assign out_ch.year         = pipe_r[NS-1].year;
  assign out_ch.year_day     = pipe_r[NS-1].year_day;
  assign out_ch.week_day     = pipe_r[NS-1].week_day;
  assign out_ch.out_of_range = pipe_r[NS-1].flag;

`include "epoch_us_to_calendar_date_macros.svh"

  `EUCD_CHECK(a_sat_fields, out_ch.valid && out_ch.out_of_range,
              out_ch.year == 12'd2099 && out_ch.year_day == 9'd364 &&
              out_ch.week_day == 3'd4 && out_ch.hour == 5'd23,
              "saturated result is not the last instant of 2099")
  `EUCD_CHECK(a_leap_days, out_ch.valid && out_ch.year[1:0] != 2'b00,
              out_ch.year_day < 9'd365, "day 365 in a common year")
  `EUCD_CHECK(a_backpressure, !in_ch.ready, out_ch.valid && !out_ch.ready,
              "input stalled while the pipeline can move")
  `EUCD_CHECK_NEXT(a_enter, in_ch.valid && in_ch.ready, v_r[0],
                   "accepted beat not captured in the first stage")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch to calendar date: testbench
// Sends microsecond timestamps through the valid/ready input and checks each
// result beat against a date predictor. Covers day, month, year and leap-day
// boundaries, the saturation past 2099, random stamps, steady streaming with
// no idle cycles, and a long result stall that backs up the pipeline.
// ----------------------------------------------------------------------------

module testbench;

  localparam logic [63:0] LAST_END  = 64'd4102444800000000;  // 2100-01-01 00:00:00
  localparam logic [63:0] US_IN_SEC = 64'd1000000;
  localparam logic [63:0] SEC_IN_DAY = 64'd86400;
  localparam int          SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [19:0] microsecond;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
    logic [8:0]  year_day;
    logic [2:0]  week_day;
    logic        out_of_range;
  } date_t;

  typedef struct packed {
    logic [63:0] stamp;
    date_t       date;
  } due_date_t;

  logic clk;
  logic rst_n;

  eucd_in_if  in_bus ();
  eucd_out_if out_bus ();

  epoch_us_to_calendar_date uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  due_date_t dates_due[$];
  int        mismatch_count = 0;
  bit        send_steady = 1'b0;
  bit        recv_steady = 1'b0;
  int        hold_request = 0;
  int        hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // days before the first of month idx (0 = January)
  function automatic logic [63:0] days_before(input int idx, input logic leap);
    logic [63:0] base;
    case (idx)
      0: base = 64'd0;
      1: base = 64'd31;
      2: base = 64'd59;
      3: base = 64'd90;
      4: base = 64'd120;
      5: base = 64'd151;
      6: base = 64'd181;
      7: base = 64'd212;
      8: base = 64'd243;
      9: base = 64'd273;
      10: base = 64'd304;
      11: base = 64'd334;
      default: base = 64'd365;
    endcase
    if (leap && idx >= 2) begin
      base = base + 64'd1;
    end
    return base;
  endfunction

  function automatic logic [63:0] jan1_day(input int unsigned yr);
    return 64'((yr - 1970) * 365 + (yr - 1969) / 4);
  endfunction

  function automatic logic [63:0] stamp_at(input logic [63:0] day, input int unsigned sec,
                                           input int unsigned us);
    return (day * SEC_IN_DAY + 64'(sec)) * US_IN_SEC + 64'(us);
  endfunction

  function automatic date_t calendar_of(input logic [63:0] stamp);
    logic [63:0] t;
    logic [63:0] secs;
    logic [63:0] days;
    logic [63:0] day_secs;
    logic [63:0] years;
    logic [63:0] yday;
    logic [63:0] yr;
    logic        leap;
    int          mon;
    int          m;
    date_t       d;
    d = '0;
    t = stamp;
    d.out_of_range = (stamp >= LAST_END);
    if (d.out_of_range) begin
      t = LAST_END - 64'd1;
    end
    secs     = t / US_IN_SEC;
    days     = secs / SEC_IN_DAY;
    day_secs = secs % SEC_IN_DAY;
    // four-year cycle of 1461 days, counted from 1970 (two years before a leap year)
    years = (days - (days + 64'd365) / 64'd1460) / 64'd365;
    yday  = days - (years * 64'd365 + (years + 64'd1) / 64'd4);
    yr    = 64'd1970 + years;
    leap  = (yr[1:0] == 2'b00);
    mon = 1;
    for (m = 1; m < 12; m++) begin
      if (yday >= days_before(m, leap)) begin
        mon = m + 1;
      end
    end
    d.microsecond  = 20'(t % US_IN_SEC);
    d.second       = 6'(day_secs % 64'd60);
    d.minute       = 6'((day_secs % 64'd3600) / 64'd60);
    d.hour         = 5'(day_secs / 64'd3600);
    d.day_of_month = 5'(64'd1 + yday - days_before(mon - 1, leap));
    d.month        = 4'(mon);
    d.year         = 12'(yr);
    d.year_day     = 9'(yday);
    d.week_day     = 3'((days + 64'd4) % 64'd7);  // 1970-01-01 was a Thursday
    return d;
  endfunction

  // mostly in range, some raw 64-bit values, the rest on month and year edges
  function automatic logic [63:0] random_stamp();
    logic [63:0] raw;
    logic [63:0] day;
    int unsigned pick;
    int unsigned yr;
    int          idx;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 10) begin
      return raw;
    end
    if (pick < 70) begin
      return raw % LAST_END;
    end
    yr  = 1970 + $urandom_range(129);
    idx = $urandom_range(11);
    day = jan1_day(yr) + days_before(idx, yr % 4 == 0);
    case ($urandom_range(2))
      0: return stamp_at(day, 0, 0) - 64'd1;
      1: return stamp_at(day, 0, 0);
      default: return stamp_at(day, $urandom_range(86399), $urandom_range(999999));
    endcase
  endfunction

  function automatic string show_date(input date_t d);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d.%0d yday %0d wday %0d ovf %0b",
                     d.year, d.month, d.day_of_month, d.hour, d.minute, d.second,
                     d.microsecond, d.year_day, d.week_day, d.out_of_range);
  endfunction

  // Called and returns at a rising edge; returns at the edge where the beat is taken.
  task automatic send_stamp(input logic [63:0] stamp);
    while (!send_steady && $urandom_range(99) < 17) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.timestamp_us <= stamp;
    do @(negedge clk); while (in_bus.ready !== 1'b1);
    dates_due.push_back('{stamp: stamp, date: calendar_of(stamp)});
    @(posedge clk);
  endtask

  // result side: random idling, plus a counted hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (recv_steady) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= 17);
      end
    end
  end

  // values are settled at the falling edge; the beat lands on the next rising edge
  always @(negedge clk) begin : check_results
    date_t     got;
    due_date_t due;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got = {out_bus.microsecond, out_bus.second, out_bus.minute, out_bus.hour,
             out_bus.day_of_month, out_bus.month, out_bus.year, out_bus.year_day,
             out_bus.week_day, out_bus.out_of_range};
      if (dates_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: unexpected result beat: %s", $realtime, show_date(got));
        end
      end else begin
        due = dates_due.pop_front();
        if (got.microsecond !== due.date.microsecond || got.second !== due.date.second ||
            got.minute !== due.date.minute || got.hour !== due.date.hour ||
            got.day_of_month !== due.date.day_of_month || got.month !== due.date.month ||
            got.year !== due.date.year || got.year_day !== due.date.year_day ||
            got.week_day !== due.date.week_day ||
            got.out_of_range !== due.date.out_of_range) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch for stamp %0d", $realtime, due.stamp);
            $display("  expected %s", show_date(due.date));
            $display("  actual   %s", show_date(got));
          end
        end
      end
    end
  end

  task automatic test_directed_edges();
    logic [63:0] picks[$];
    picks = '{
      64'd0,
      stamp_at(0, 0, 999999),
      stamp_at(0, 86399, 999999),
      stamp_at(jan1_day(1973) - 1, 43210, 5),     // last day of a leap year
      stamp_at(jan1_day(1973), 0, 0),
      stamp_at(jan1_day(2000) + 59, 0, 0),         // leap day
      stamp_at(jan1_day(2000) + 59, 86399, 999999),
      stamp_at(jan1_day(2000) + 60, 0, 0),
      stamp_at(jan1_day(2099) + 58, 86399, 999999),
      stamp_at(jan1_day(2099) + 59, 0, 0),
      stamp_at(jan1_day(2096) + 365, 86399, 999999),
      stamp_at(jan1_day(2038), 11045, 123456),
      LAST_END - 64'd1,
      LAST_END,
      LAST_END + 64'd1,
      64'h8000_0000_0000_0000,
      64'h5555_5555_5555_5555,
      64'hAAAA_AAAA_AAAA_AAAA,
      64'hFFFF_FFFF_FFFF_FFFF
    };
    foreach (picks[i]) begin
      send_stamp(picks[i]);
    end
  endtask

  task automatic test_random_stamps(input int count);
    repeat (count) send_stamp(random_stamp());
  endtask

  task automatic test_steady_stream(input int count);
    send_steady = 1'b1;
    recv_steady = 1'b1;
    repeat (count) send_stamp(random_stamp());
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  // result side holds off while inputs keep coming, so the pipeline fills
  task automatic test_result_stall(input int count);
    hold_request = 80;
    send_steady  = 1'b1;
    repeat (count) send_stamp(random_stamp());
    send_steady  = 1'b0;
  endtask

  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.timestamp_us = 64'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_random_stamps(150);
    test_steady_stream(100);
    test_result_stall(40);
    test_random_stamps(110);

    in_bus.valid <= 1'b0;
    while (dates_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
